// ===== rtl/grid_max_min_distance_path_defines.svh =====
// Assertion macros for the grid widest-path block.
`ifndef GRID_MAX_MIN_DISTANCE_PATH_DEFINES_SVH
`define GRID_MAX_MIN_DISTANCE_PATH_DEFINES_SVH

// same-cycle implication
`define GMMDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GMMDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gmmdp_pkg.sv =====
// Package: sizes, state codes and neighbor helper for the grid widest-path block.
`default_nettype none
package gmmdp_pkg;
	localparam int MAX_SIDE = 64;
	localparam int CW       = $clog2(MAX_SIDE);
	localparam int AW       = 2 * CW;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int CNT_W    = AW + 1;
	localparam int SIDE_W   = 7;
	localparam int VAL_W    = 7;
	localparam int DIST_W   = 8;
	localparam int KEY_W    = VAL_W + AW;

	localparam logic [DIST_W-1:0] UNVISITED = '1;

	typedef logic [1:0] dir_t;
	localparam dir_t DIR_RIGHT = 2'd0;
	localparam dir_t DIR_DOWN  = 2'd1;
	localparam dir_t DIR_LEFT  = 2'd2;
	localparam dir_t DIR_UP    = 2'd3;

	typedef struct packed {
		logic          ok;
		logic [CW-1:0] r;
		logic [CW-1:0] c;
	} nb_t;

	typedef enum logic [4:0] {
		S_LOAD, S_INIT, S_INIT_END, S_DEC,
		S_B_RDQ, S_B_CUR, S_B_DCUR, S_B_NB, S_B_CHK,
		S_H_INIT, S_H_INIT2, S_PUSH, S_PUSH_CMP,
		S_POP0, S_POP1, S_POP2, S_SD_L, S_SD_R, S_SD_CMP,
		S_H_NB, S_H_CHK, S_FINISH
	} state_t;

	function automatic logic [CW-1:0] last_coord(input logic [SIDE_W-1:0] s);
		logic [CW-1:0] res;
		if (s == '0)
			res = '0;
		else if (int'(s) > MAX_SIDE)
			res = CW'(MAX_SIDE - 1);
		else
			res = CW'(s - 1'b1);
		return res;
	endfunction

	function automatic nb_t nb_calc(input logic [CW-1:0] r, input logic [CW-1:0] c,
		input dir_t k, input logic [CW-1:0] nm1);
		nb_t n;
		n.ok = 1'b0;
		n.r  = r;
		n.c  = c;
		unique case (k)
			DIR_RIGHT: begin
				n.ok = (c != nm1);
				n.c  = c + 1'b1;
			end
			DIR_DOWN: begin
				n.ok = (r != nm1);
				n.r  = r + 1'b1;
			end
			DIR_LEFT: begin
				n.ok = (c != '0);
				n.c  = c - 1'b1;
			end
			DIR_UP: begin
				n.ok = (r != '0);
				n.r  = r - 1'b1;
			end
		endcase
		return n;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/gmmdp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gmmdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/grid_max_min_distance_path.sv =====
// Top level: grid load, BFS distance transform and max-heap widest-path search.
// Load: one cell per cycle, n*n transactions for an n-by-n grid.
// Compute after the last cell: a clear/seed sweep of every cell, a BFS from the marked cells,
// then a max-heap search that pops a cell, pushes its unvisited neighbors and sifts the heap.
// Result sits in an output register; the next grid loads while it waits.
// Reset (async, active low): control cleared, grid_side 64; RAM contents are left as is.
`default_nettype none
module grid_max_min_distance_path (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [gmmdp_pkg::SIDE_W-1:0]   cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cell_marked,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [gmmdp_pkg::VAL_W-1:0]    best_min_distance,
	output logic                                no_marked_cell
);
	import gmmdp_pkg::*;

	state_t              state_q, state_d;
	logic [SIDE_W-1:0]   side_q, side_d;
	logic [CW-1:0]       load_r_q, load_r_d, load_c_q, load_c_d;
	logic [CW-1:0]       sr_q, sr_d, sc_q, sc_d;
	logic                vld_s1, vld_d;
	logic [CW-1:0]       ar_s1, ar_d, ac_s1, ac_d;
	logic [CNT_W-1:0]    tail_q, tail_d, head_q, head_d, hl_q, hl_d;
	logic                corner_q, corner_d, push_init_q, push_init_d;
	logic [CW-1:0]       cur_r_q, cur_r_d, cur_c_q, cur_c_d, nb_r_q, nb_r_d, nb_c_q, nb_c_d;
	logic [DIST_W-1:0]   cur_d_q, cur_d_d;
	dir_t                k_q, k_d;
	logic [KEY_W-1:0]    key_q, key_d, lval_q, lval_d;
	logic [AW-1:0]       hi_q, hi_d, par_q, par_d;
	logic [VAL_W-1:0]    res_val_q, res_val_d, out_val_q, out_val_d;
	logic                res_flag_q, res_flag_d, out_flag_q, out_flag_d;
	logic                out_valid_q, out_valid_d;

	logic                cell_we, cell_rd;
	logic [AW-1:0]       cell_waddr, cell_raddr;
	logic                dist_we;
	logic [AW-1:0]       dist_waddr, dist_raddr;
	logic [DIST_W-1:0]   dist_wdata, dist_rd;
	logic                vis_we, vis_wdata, vis_rd;
	logic [AW-1:0]       vis_waddr, vis_raddr;
	logic                q_we;
	logic [AW-1:0]       q_waddr, q_raddr, q_wdata, q_rd;
	logic                h_we;
	logic [AW-1:0]       h_waddr, h_raddr;
	logic [KEY_W-1:0]    h_wdata, h_rd;

	logic [CW-1:0]       nm1;
	logic                in_acc;
	nb_t                 nb;
	logic [CNT_W-1:0]    l_idx, r_idx;
	logic [VAL_W-1:0]    nv;
	logic [KEY_W-1:0]    best;
	logic [AW-1:0]       m_idx;

	assign nm1    = last_coord(side_q);
	assign in_acc = in_valid && in_ready;
	assign nb     = nb_calc(cur_r_q, cur_c_q, k_q, nm1);
	assign l_idx  = {hi_q, 1'b1};
	assign r_idx  = {hi_q, 1'b0} + CNT_W'(2);

	gmmdp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cell_ram (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_marked),
		.raddr(cell_raddr), .rdata(cell_rd));
	gmmdp_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr), .rdata(dist_rd));
	gmmdp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rd));
	gmmdp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rd));
	gmmdp_ram #(.WIDTH(KEY_W), .DEPTH(CELLS)) u_heap_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rd));

	always_comb begin
		state_d     = state_q;
		side_d      = side_q;
		load_r_d    = load_r_q;
		load_c_d    = load_c_q;
		sr_d        = sr_q;
		sc_d        = sc_q;
		vld_d       = 1'b0;
		ar_d        = sr_q;
		ac_d        = sc_q;
		tail_d      = tail_q;
		head_d      = head_q;
		hl_d        = hl_q;
		corner_d    = corner_q;
		push_init_d = push_init_q;
		cur_r_d     = cur_r_q;
		cur_c_d     = cur_c_q;
		cur_d_d     = cur_d_q;
		nb_r_d      = nb_r_q;
		nb_c_d      = nb_c_q;
		k_d         = k_q;
		key_d       = key_q;
		lval_d      = lval_q;
		hi_d        = hi_q;
		par_d       = par_q;
		res_val_d   = res_val_q;
		res_flag_d  = res_flag_q;
		out_val_d   = out_val_q;
		out_flag_d  = out_flag_q;
		out_valid_d = out_valid_q && !out_ready;

		in_ready    = (state_q == S_LOAD);
		cell_we     = 1'b0;
		cell_waddr  = {load_r_q, load_c_q};
		cell_raddr  = {sr_q, sc_q};
		dist_we     = 1'b0;
		dist_waddr  = {nb_r_q, nb_c_q};
		dist_wdata  = cur_d_q + 1'b1;
		dist_raddr  = {nb.r, nb.c};
		vis_we      = 1'b0;
		vis_waddr   = {nb_r_q, nb_c_q};
		vis_wdata   = 1'b1;
		vis_raddr   = {nb.r, nb.c};
		q_we        = 1'b0;
		q_waddr     = tail_q[AW-1:0];
		q_wdata     = {nb_r_q, nb_c_q};
		q_raddr     = head_q[AW-1:0];
		h_we        = 1'b0;
		h_waddr     = hi_q;
		h_wdata     = key_q;
		h_raddr     = par_q;
		nv          = (dist_rd[VAL_W-1:0] < cur_d_q[VAL_W-1:0]) ?
			dist_rd[VAL_W-1:0] : cur_d_q[VAL_W-1:0];
		best        = key_q;
		m_idx       = hi_q;

		// seed sweep write-back, in the cycle after the cell read
		if (vld_s1) begin
			dist_we    = 1'b1;
			dist_waddr = {ar_s1, ac_s1};
			dist_wdata = cell_rd ? '0 : UNVISITED;
			vis_we     = 1'b1;
			vis_waddr  = {ar_s1, ac_s1};
			vis_wdata  = 1'b0;
			if (cell_rd) begin
				q_we    = 1'b1;
				q_wdata = {ar_s1, ac_s1};
				tail_d  = tail_q + 1'b1;
				if ((ar_s1 == '0 && ac_s1 == '0) || (ar_s1 == nm1 && ac_s1 == nm1))
					corner_d = 1'b1;
			end
		end

		unique case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					cell_we = 1'b1;
					if (load_c_q == nm1) begin
						load_c_d = '0;
						if (load_r_q == nm1) begin
							load_r_d = '0;
							sr_d     = '0;
							sc_d     = '0;
							tail_d   = '0;
							head_d   = '0;
							hl_d     = '0;
							corner_d = 1'b0;
							state_d  = S_INIT;
						end else begin
							load_r_d = load_r_q + 1'b1;
						end
					end else begin
						load_c_d = load_c_q + 1'b1;
					end
				end
			end
			S_INIT: begin
				vld_d   = 1'b1;
				if (sc_q == nm1) begin
					sc_d = '0;
					sr_d = sr_q + 1'b1;
					if (sr_q == nm1)
						state_d = S_INIT_END;
				end else begin
					sc_d = sc_q + 1'b1;
				end
			end
			S_INIT_END: begin
				state_d = S_DEC;
			end
			S_DEC: begin
				head_d = '0;
				if (corner_q) begin
					res_val_d  = '0;
					res_flag_d = 1'b0;
					state_d    = S_FINISH;
				end else if (tail_q == '0) begin
					res_val_d  = '0;
					res_flag_d = 1'b1;
					state_d    = S_FINISH;
				end else begin
					state_d = S_B_RDQ;
				end
			end
			S_B_RDQ: begin
				head_d  = head_q + 1'b1;
				state_d = S_B_CUR;
			end
			S_B_CUR: begin
				cur_r_d    = q_rd[AW-1:CW];
				cur_c_d    = q_rd[CW-1:0];
				dist_raddr = q_rd;
				state_d    = S_B_DCUR;
			end
			S_B_DCUR: begin
				cur_d_d = dist_rd;
				k_d     = DIR_RIGHT;
				state_d = S_B_NB;
			end
			S_B_NB, S_B_CHK: begin
				if (state_q == S_B_NB && nb.ok) begin
					nb_r_d  = nb.r;
					nb_c_d  = nb.c;
					state_d = S_B_CHK;
				end else begin
					if (state_q == S_B_CHK && dist_rd == UNVISITED) begin
						dist_we = 1'b1;
						q_we    = 1'b1;
						tail_d  = tail_q + 1'b1;
					end
					if (k_q == DIR_UP)
						state_d = (head_q < tail_d) ? S_B_RDQ : S_H_INIT;
					else begin
						k_d     = k_q + 1'b1;
						state_d = S_B_NB;
					end
				end
			end
			S_H_INIT: begin
				vis_we     = 1'b1;
				vis_waddr  = '0;
				dist_raddr = '0;
				state_d    = S_H_INIT2;
			end
			S_H_INIT2: begin
				key_d       = {dist_rd[VAL_W-1:0], AW'(0)};
				hi_d        = hl_q[AW-1:0];
				hl_d        = hl_q + 1'b1;
				push_init_d = 1'b1;
				state_d     = S_PUSH;
			end
			S_PUSH, S_PUSH_CMP: begin
				if (state_q == S_PUSH && hi_q != '0) begin
					par_d   = (hi_q - 1'b1) >> 1;
					h_raddr = (hi_q - 1'b1) >> 1;
					state_d = S_PUSH_CMP;
				end else if (state_q == S_PUSH_CMP && h_rd < key_q) begin
					h_we    = 1'b1;
					h_wdata = h_rd;
					hi_d    = par_q;
					state_d = S_PUSH;
				end else begin
					h_we = 1'b1;
					if (push_init_q) begin
						push_init_d = 1'b0;
						state_d     = S_POP0;
					end else if (k_q == DIR_UP) begin
						state_d = S_POP0;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_H_NB;
					end
				end
			end
			S_POP0: begin
				h_raddr = '0;
				state_d = S_POP1;
			end
			S_POP1: begin
				if (h_rd[AW-1:0] == {nm1, nm1}) begin
					res_val_d  = h_rd[KEY_W-1:AW];
					res_flag_d = 1'b0;
					state_d    = S_FINISH;
				end else begin
					cur_d_d = DIST_W'(h_rd[KEY_W-1:AW]);
					cur_r_d = h_rd[AW-1:CW];
					cur_c_d = h_rd[CW-1:0];
					h_raddr = hl_q[AW-1:0] - 1'b1;
					hl_d    = hl_q - 1'b1;
					state_d = S_POP2;
				end
			end
			S_POP2: begin
				key_d   = h_rd;
				hi_d    = '0;
				state_d = S_SD_L;
			end
			S_SD_L: begin
				h_raddr = l_idx[AW-1:0];
				if (l_idx >= hl_q) begin
					h_we    = 1'b1;
					k_d     = DIR_RIGHT;
					state_d = S_H_NB;
				end else begin
					state_d = S_SD_R;
				end
			end
			S_SD_R: begin
				lval_d  = h_rd;
				h_raddr = r_idx[AW-1:0];
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				if (lval_q > best) begin
					best  = lval_q;
					m_idx = l_idx[AW-1:0];
				end
				if (r_idx < hl_q && h_rd > best) begin
					best  = h_rd;
					m_idx = r_idx[AW-1:0];
				end
				h_we = 1'b1;
				if (m_idx == hi_q) begin
					k_d     = DIR_RIGHT;
					state_d = S_H_NB;
				end else begin
					h_wdata = best;
					hi_d    = m_idx;
					state_d = S_SD_L;
				end
			end
			S_H_NB, S_H_CHK: begin
				if (state_q == S_H_NB && nb.ok) begin
					nb_r_d  = nb.r;
					nb_c_d  = nb.c;
					state_d = S_H_CHK;
				end else if (state_q == S_H_CHK && !vis_rd) begin
					vis_we  = 1'b1;
					key_d   = {nv, nb_r_q, nb_c_q};
					hi_d    = hl_q[AW-1:0];
					hl_d    = hl_q + 1'b1;
					state_d = S_PUSH;
				end else if (k_q == DIR_UP) begin
					if (hl_q != '0)
						state_d = S_POP0;
					else begin
						res_val_d  = '0;
						res_flag_d = 1'b0;
						state_d    = S_FINISH;
					end
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_H_NB;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_val_d   = res_val_q;
					out_flag_d  = res_flag_q;
					out_valid_d = 1'b1;
					state_d     = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase

		if (cfg_wr_en) begin
			side_d   = cfg_wr_data;
			load_r_d = '0;
			load_c_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			side_q      <= SIDE_W'(MAX_SIDE);
			load_r_q    <= '0;
			load_c_q    <= '0;
			vld_s1      <= 1'b0;
			tail_q      <= '0;
			head_q      <= '0;
			hl_q        <= '0;
			corner_q    <= 1'b0;
			push_init_q <= 1'b0;
			k_q         <= DIR_RIGHT;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			side_q      <= side_d;
			load_r_q    <= load_r_d;
			load_c_q    <= load_c_d;
			vld_s1      <= vld_d;
			tail_q      <= tail_d;
			head_q      <= head_d;
			hl_q        <= hl_d;
			corner_q    <= corner_d;
			push_init_q <= push_init_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sr_q       <= sr_d;
		sc_q       <= sc_d;
		ar_s1      <= ar_d;
		ac_s1      <= ac_d;
		cur_r_q    <= cur_r_d;
		cur_c_q    <= cur_c_d;
		cur_d_q    <= cur_d_d;
		nb_r_q     <= nb_r_d;
		nb_c_q     <= nb_c_d;
		key_q      <= key_d;
		lval_q     <= lval_d;
		hi_q       <= hi_d;
		par_q      <= par_d;
		res_val_q  <= res_val_d;
		res_flag_q <= res_flag_d;
		out_val_q  <= out_val_d;
		out_flag_q <= out_flag_d;
	end

	assign out_valid         = out_valid_q;
	assign best_min_distance = out_val_q;
	assign no_marked_cell    = out_flag_q;

`include "grid_max_min_distance_path_defines.svh"

	`GMMDP_ASSERT_NOW(a_queue_order, 1'b1, head_q <= tail_q && tail_q <= CNT_W'(CELLS), "bfs queue pointers out of order")
	`GMMDP_ASSERT_NOW(a_heap_len, 1'b1, hl_q <= CNT_W'(CELLS), "heap length above capacity")
	`GMMDP_ASSERT_NOW(a_flag_zero, out_valid && no_marked_cell, best_min_distance == '0, "empty grid result not zero")
	`GMMDP_ASSERT_NEXT(a_last_cell, in_acc && load_r_q == nm1 && load_c_q == nm1 && !cfg_wr_en, !in_ready, "still ready after last cell")
endmodule
`default_nettype wire
